@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define BIR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is held.
`define BIR_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define BIR_ASSERT_NXT_ANY(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bir_pkg.sv @@
// ---------------------------------------------------------------------------
// bir_pkg
// Types and fixed widths shared by the bilinear resize block.
// ---------------------------------------------------------------------------
package bir_pkg;

  localparam int POS_W      = 8;   // pixel coordinate on the streams
  localparam int CHAN_W     = 8;   // one color channel
  localparam int SIZE_W     = 9;   // source width and height registers
  localparam int CNT_W      = 2;   // channel count register
  localparam int SCALE_W    = 24;  // Q8.16 scale registers
  localparam int IDX_W      = 9;   // mapped source index
  localparam int FRAC_W     = 8;   // interpolation weight fraction
  localparam int OUT_CH     = 3;   // channels carried on the streams
  localparam int IN_DATA_W  = 2 * POS_W + OUT_CH * CHAN_W;
  localparam int OUT_DATA_W = 2 * POS_W + OUT_CH * CHAN_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // (2d+1)*scale holds the source coordinate in units of 2^-17.
  localparam int PROD_W     = POS_W + 1 + SCALE_W;
  localparam int IP_LSB     = 17;
  localparam int FRAC_LSB   = IP_LSB - FRAC_W;
  localparam int Q16_ONE    = 65536;
  localparam int WEIGHT_ONE = 256;
  localparam int ROUND_HALF = 32768;

  typedef enum logic {
    REQ_LOAD     = 1'b0,
    REQ_RESAMPLE = 1'b1
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_CHAN_COUNT = 3'd2,
    CFG_SCALE_X    = 3'd3,
    CFG_SCALE_Y    = 3'd4
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAP,
    ST_ADDR,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_FIN,
    ST_VERT
  } state_t;

  typedef struct packed {
    logic hold_near;
    logic calc_top;
    logic calc_bot;
  } lane_ctl_t;

endpackage

@@ rtl/bilinear_image_resize.sv @@
// ---------------------------------------------------------------------------
// bilinear_image_resize
// Frame store plus bilinear resampler with half-pixel centers.
// ---------------------------------------------------------------------------
// Usage:
//   The in_ stream carries requests. in_tuser = 0 loads one source pixel
//   (pos_x, pos_y, three samples) into the frame store; in_tuser = 1 asks
//   for destination pixel (pos_x, pos_y). The out_ stream returns one item
//   per resample request: its coordinates and three interpolated channels,
//   unused channels as zero. The cfg_ port writes the source size, channel
//   count and the two Q8.16 scales; it is always ready, and the user writes
//   it only while no request is in flight; the block does not enforce this.
//   Loads can stream back to back while the block is idle. A resample
//   occupies the block through coordinate mapping, address forming, the
//   four neighbor reads from the single-port frame store and the vertical
//   pass; no further request is taken until it has finished.
//   Reset returns the controller to idle, drops any pending result and loads
//   the default configuration; the frame store keeps no reset value and must
//   be loaded before it is sampled. While the receiver stalls, the result
//   holds in the output register and further loads are still taken; the next
//   resample waits in its final step until the output register frees up.
// ---------------------------------------------------------------------------
module bilinear_image_resize import bir_pkg::*; #(
  parameter int MAX_SRC_WIDTH  = 256,
  parameter int MAX_SRC_HEIGHT = 256,
  parameter int MAX_CHANNELS   = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pos_x, pos_y, sample0, sample1, sample2
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // req_type
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // dest_x, dest_y, value0, value1, value2
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int DEPTH  = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int AW     = $clog2(DEPTH);
  localparam int WORD_W = CHAN_W * MAX_CHANNELS;
  localparam int NL     = (MAX_CHANNELS < OUT_CH) ? MAX_CHANNELS : OUT_CH;

  state_t state_r, state_nxt;

  logic [SIZE_W-1:0]  src_w_r, src_h_r;
  logic [CNT_W-1:0]   chan_r;
  logic [SCALE_W-1:0] scale_x_r, scale_y_r;

  logic [POS_W-1:0]  px_r, py_r;
  logic [AW-1:0]     base_r;
  logic              out_tvalid_r;
  logic [OUT_DATA_W-1:0] out_tdata_r;

  logic [POS_W-1:0]  in_px, in_py;
  logic              in_fire, load_fire, load_ok;
  logic [AW-1:0]     load_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata, ram_rdata;
  logic              coord_en, base_en, out_load;
  lane_ctl_t         lane_ctl;
  logic [IDX_W-1:0]  sx, sy;
  logic [FRAC_W-1:0] fx, fy;
  logic [CNT_W-1:0]  chan_eff;
  logic [CHAN_W-1:0] lane_val [NL];
  logic [CHAN_W-1:0] merged [OUT_CH];

  assign in_px     = in_tdata[0 +: POS_W];
  assign in_py     = in_tdata[POS_W +: POS_W];
  assign in_fire   = in_tvalid && in_tready;
  assign load_ok   = (int'(in_px) < MAX_SRC_WIDTH) && (int'(in_py) < MAX_SRC_HEIGHT);
  assign load_fire = in_fire && (req_t'(in_tuser) == REQ_LOAD);
  assign load_addr = AW'(int'(in_py) * MAX_SRC_WIDTH + int'(in_px));

  // Store channels beyond the three sample inputs are written as zero.
  for (genvar c = 0; c < MAX_CHANNELS; c++) begin : g_wdata
    if (c < OUT_CH) begin : g_smp
      assign ram_wdata[c*CHAN_W +: CHAN_W] = in_tdata[2*POS_W + c*CHAN_W +: CHAN_W];
    end else begin : g_zero
      assign ram_wdata[c*CHAN_W +: CHAN_W] = '0;
    end
  end

  // Configuration registers.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r   <= SIZE_W'(256);
      src_h_r   <= SIZE_W'(256);
      chan_r    <= CNT_W'(3);
      scale_x_r <= SCALE_W'(Q16_ONE);
      scale_y_r <= SCALE_W'(Q16_ONE);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SRC_WIDTH:  src_w_r   <= cfg_data[SIZE_W-1:0];
        CFG_SRC_HEIGHT: src_h_r   <= cfg_data[SIZE_W-1:0];
        CFG_CHAN_COUNT: chan_r    <= cfg_data[CNT_W-1:0];
        CFG_SCALE_X:    scale_x_r <= cfg_data[SCALE_W-1:0];
        CFG_SCALE_Y:    scale_y_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (req_t'(in_tuser) == REQ_RESAMPLE)) begin
          state_nxt = ST_MAP;
        end
      end
      ST_MAP:  state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_RD0;
      ST_RD0:  state_nxt = ST_RD1;
      ST_RD1:  state_nxt = ST_RD2;
      ST_RD2:  state_nxt = ST_RD3;
      ST_RD3:  state_nxt = ST_FIN;
      ST_FIN:  state_nxt = ST_VERT;
      ST_VERT: begin
        if (!out_tvalid_r || out_tready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Controller outputs. Read data arrives in the cycle after its address.
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = load_addr;
    coord_en  = 1'b0;
    base_en   = 1'b0;
    out_load  = 1'b0;
    lane_ctl  = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ram_we    = load_fire && load_ok;
      end
      ST_MAP:  coord_en = 1'b1;
      ST_ADDR: base_en  = 1'b1;
      ST_RD0:  ram_addr = base_r;
      ST_RD1: begin
        ram_addr           = base_r + AW'(1);
        lane_ctl.hold_near = 1'b1;
      end
      ST_RD2: begin
        ram_addr          = base_r + AW'(MAX_SRC_WIDTH);
        lane_ctl.calc_top = 1'b1;
      end
      ST_RD3: begin
        ram_addr           = base_r + AW'(MAX_SRC_WIDTH + 1);
        lane_ctl.hold_near = 1'b1;
      end
      ST_FIN:  lane_ctl.calc_bot = 1'b1;
      ST_VERT: out_load = !out_tvalid_r || out_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_fire) begin
      px_r <= in_px;
      py_r <= in_py;
    end
    if (base_en) begin
      base_r <= AW'(int'(sy) * MAX_SRC_WIDTH + int'(sx));
    end
  end

  bir_coord #(.MAX_SIZE(MAX_SRC_WIDTH)) u_coord_x (
    .clk      (clk),
    .en       (coord_en),
    .pos      (px_r),
    .scale    (scale_x_r),
    .size_cfg (src_w_r),
    .idx_r    (sx),
    .frac_r   (fx)
  );

  bir_coord #(.MAX_SIZE(MAX_SRC_HEIGHT)) u_coord_y (
    .clk      (clk),
    .en       (coord_en),
    .pos      (py_r),
    .scale    (scale_y_r),
    .size_cfg (src_h_r),
    .idx_r    (sy),
    .frac_r   (fy)
  );

  bir_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  for (genvar k = 0; k < NL; k++) begin : g_lane
    bir_lane u_lane (
      .clk   (clk),
      .ctl   (lane_ctl),
      .pix   (ram_rdata[k*CHAN_W +: CHAN_W]),
      .fx    (fx),
      .fy    (fy),
      .value (lane_val[k])
    );
  end

  // Merge: channels past the configured count read as zero.
  assign chan_eff = (chan_r == '0) ? CNT_W'(1) : chan_r;

  for (genvar k = 0; k < OUT_CH; k++) begin : g_merge
    if (k < NL) begin : g_used
      assign merged[k] = (CNT_W'(k) < chan_eff) ? lane_val[k] : '0;
    end else begin : g_none
      assign merged[k] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tdata_r <= {merged[2], merged[1], merged[0], py_r, px_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule

@@ rtl/bir_ram.sv @@
// ---------------------------------------------------------------------------
// bir_ram
// Single-port RAM with a registered read; a write cycle does not read.
// ---------------------------------------------------------------------------
module bir_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else begin
      rdata <= mem[addr];
    end
  end

endmodule

@@ rtl/bir_coord.sv @@
// ---------------------------------------------------------------------------
// bir_coord
// Maps a destination coordinate to a source index and 8-bit fraction.
// ---------------------------------------------------------------------------
module bir_coord import bir_pkg::*; #(
  parameter int MAX_SIZE = 256
) (
  input  logic              clk,
  input  logic              en,
  input  logic [POS_W-1:0]  pos,
  input  logic [SCALE_W-1:0] scale,
  input  logic [SIZE_W-1:0] size_cfg,
  output logic [IDX_W-1:0]  idx_r,
  output logic [FRAC_W-1:0] frac_r
);

  localparam int IP_W = PROD_W - IP_LSB;

  logic [PROD_W-1:0] prod;
  logic [PROD_W-1:0] shifted;
  logic              neg;
  logic [SIZE_W-1:0] lim;
  logic [IP_W-1:0]   ip;
  logic [IDX_W-1:0]  idx_nxt;
  logic [FRAC_W-1:0] frac_nxt;

  always_comb begin
    prod    = PROD_W'({pos, 1'b1}) * PROD_W'(scale);
    neg     = prod < PROD_W'(Q16_ONE);
    shifted = prod - PROD_W'(Q16_ONE);
    ip      = shifted[PROD_W-1:IP_LSB];

    // Highest usable index is the clamped size minus two.
    if (size_cfg < SIZE_W'(2)) begin
      lim = '0;
    end else if (int'(size_cfg) > MAX_SIZE) begin
      lim = SIZE_W'(MAX_SIZE - 2);
    end else begin
      lim = size_cfg - SIZE_W'(2);
    end

    if (neg) begin
      idx_nxt  = '0;
      frac_nxt = '0;
    end else if (ip > IP_W'(lim)) begin
      idx_nxt  = IDX_W'(lim);
      frac_nxt = '0;
    end else begin
      idx_nxt  = ip[IDX_W-1:0];
      frac_nxt = shifted[FRAC_LSB +: FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      idx_r  <= idx_nxt;
      frac_r <= frac_nxt;
    end
  end

endmodule

@@ rtl/bir_lane.sv @@
// ---------------------------------------------------------------------------
// bir_lane
// Interpolation core for one color channel: two horizontal passes, then
// one vertical pass with round half up.
// ---------------------------------------------------------------------------
module bir_lane import bir_pkg::*; (
  input  logic              clk,
  input  lane_ctl_t         ctl,
  input  logic [CHAN_W-1:0] pix,
  input  logic [FRAC_W-1:0] fx,
  input  logic [FRAC_W-1:0] fy,
  output logic [CHAN_W-1:0] value
);

  localparam int WGT_W = FRAC_W + 1;
  localparam int HZ_W  = CHAN_W + FRAC_W;
  localparam int VS_W  = HZ_W + WGT_W;

  logic [CHAN_W-1:0] near_r;
  logic [HZ_W-1:0]   top_r;
  logic [HZ_W-1:0]   bot_r;
  logic [WGT_W-1:0]  gx;
  logic [WGT_W-1:0]  gy;
  logic [HZ_W:0]     horiz;
  logic [VS_W-1:0]   vsum;

  always_comb begin
    gx    = WGT_W'(WEIGHT_ONE) - WGT_W'(fx);
    gy    = WGT_W'(WEIGHT_ONE) - WGT_W'(fy);
    // At most 255 * 256, so the top bit of horiz is always clear.
    horiz = (HZ_W+1)'(near_r) * (HZ_W+1)'(gx) + (HZ_W+1)'(pix) * (HZ_W+1)'(fx);
    vsum  = VS_W'(top_r) * VS_W'(gy) + VS_W'(bot_r) * VS_W'(fy) + VS_W'(ROUND_HALF);
    value = vsum[2*FRAC_W +: CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (ctl.hold_near) begin
      near_r <= pix;
    end
    if (ctl.calc_top) begin
      top_r <= horiz[HZ_W-1:0];
    end
    if (ctl.calc_bot) begin
      bot_r <= horiz[HZ_W-1:0];
    end
  end

endmodule

@@ rtl/bir_checker.sv @@
// ---------------------------------------------------------------------------
// bir_checker
// Port-level checks for the bilinear resize block, bound to its top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bir_checker import bir_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  `BIR_ASSERT_NXT_ANY(a_reset_clears_out, clk, !rst_n, !out_tvalid, "result valid after reset")

  `BIR_ASSERT_NXT(a_stall_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "stalled result changed")

  `BIR_ASSERT_NXT(a_busy_after_resample, clk, rst_n, in_tvalid && in_tready && in_tuser, !in_tready, "request taken while resampling")

  `BIR_ASSERT_IMP(a_result_has_request, clk, rst_n, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tuser, 9), "result without resample request")

  `BIR_ASSERT_IMP(a_result_coords, clk, rst_n, $rose(out_tvalid), out_tdata[2*POS_W-1:0] == $past(in_tdata[2*POS_W-1:0], 9), "result coordinates differ from request")

endmodule

bind bilinear_image_resize bir_checker u_bir_checker (.*);
